FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, ignored while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/rrts_pkg.sv
// Types and codes shared by the round robin task selector modules.
package rrts_pkg;

  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_READY    = 3'd1,
    ST_BLOCKED  = 3'd2,
    ST_SLEEPING = 3'd3,
    ST_TERM     = 3'd4,
    ST_RUNNING  = 3'd5
  } slot_state_t;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_YIELD = 3'd1,
    CMD_SLEEP = 3'd2,
    CMD_BLOCK = 3'd3,
    CMD_WAKE  = 3'd4,
    CMD_TERM  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NONE        = 2'd1,
    STAT_FULL        = 2'd2,
    STAT_NOT_BLOCKED = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] task_slot;
    logic       switched;
  } res_t;

  typedef struct packed {
    logic        st_we;
    slot_state_t st_wdata;
    logic        wk_we;
  } tbl_ctl_t;

endpackage

FILE: hw/rtl/round_robin_task_selector.sv
// Round robin task selector: top level with input capture, result register and config.
// One command at a time: the input stalls until the result is in the output register.
// Unknown codes and zero sleeps go straight to the result, wake and terminate check one slot,
// add seeks a free slot in use or appends one; yield, sleep and block scan for a task to run.
// The result word is registered and shows in the same cycle the next word can be accepted.
// Synchronous reset: slot 0 running, other slots free, one slot in use, ticks_per_us of 1.
module round_robin_task_selector #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_now_ticks,
  input  logic [31:0] in_sleep_us,
  input  logic [3:0]  in_target_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_task_slot,
  output logic        out_switched
);

  localparam int SW = $clog2(TABLE_SLOTS);

  logic [7:0]            tpu_r;
  logic [2:0]            cmd_r;
  logic [31:0]           now_r;
  logic [31:0]           us_r;
  logic [3:0]            target_r;
  logic                  out_valid_r;
  rrts_pkg::res_t        out_res_r;

  logic                  accept;
  logic                  out_free;
  logic                  idle;
  logic                  res_valid;
  rrts_pkg::res_t        res;
  logic [SW-1:0]         tbl_addr;
  rrts_pkg::tbl_ctl_t    tbl_ctl;
  logic [31:0]           wk_wdata;
  rrts_pkg::slot_state_t st_rd;
  logic [31:0]           wk_rd;

  assign in_stall      = !idle || !rst_n;
  assign accept        = in_valid && !in_stall;
  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_status    = out_res_r.status;
  assign out_task_slot = out_res_r.task_slot;
  assign out_switched  = out_res_r.switched;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r       <= 8'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tpu_r <= cfg_wdata;
      end
      if (res_valid && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      now_r    <= in_now_ticks;
      us_r     <= in_sleep_us;
      target_r <= in_target_slot;
    end
    if (res_valid && out_free) begin
      out_res_r <= res;
    end
  end

  rrts_seq #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (accept),
    .cmd          (cmd_r),
    .now_ticks    (now_r),
    .sleep_us     (us_r),
    .target_slot  (target_r),
    .ticks_per_us (tpu_r),
    .out_free     (out_free),
    .idle         (idle),
    .res_valid    (res_valid),
    .res          (res),
    .tbl_addr     (tbl_addr),
    .tbl_ctl      (tbl_ctl),
    .wk_wdata     (wk_wdata),
    .st_rd        (st_rd),
    .wk_rd        (wk_rd)
  );

  rrts_table #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .addr     (tbl_addr),
    .ctl      (tbl_ctl),
    .wk_wdata (wk_wdata),
    .st_rd    (st_rd),
    .wk_rd    (wk_rd)
  );

endmodule

FILE: hw/rtl/rrts_table.sv
// Task table: slot state flip-flops and the wake tick memory on one shared address.
module rrts_table #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [$clog2(TABLE_SLOTS)-1:0]    addr,
  input  rrts_pkg::tbl_ctl_t                ctl,
  input  logic [31:0]                       wk_wdata,
  output rrts_pkg::slot_state_t             st_rd,
  output logic [31:0]                       wk_rd
);

  rrts_pkg::slot_state_t state_r [TABLE_SLOTS];
  logic [31:0]           wake_mem [TABLE_SLOTS];
  logic [31:0]           wk_rd_r;

  assign st_rd = state_r[addr];
  assign wk_rd = wk_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        state_r[i] <= (i == 0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_FREE;
      end
    end else if (ctl.st_we) begin
      state_r[addr] <= ctl.st_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wk_we) begin
      wake_mem[addr] <= wk_wdata;
    end
    wk_rd_r <= wake_mem[addr];
  end

endmodule

FILE: hw/rtl/rrts_seq.sv
// Sequencer: one slot per cycle, plus wake checks on sleepers; one shared adder.
module rrts_seq #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [2:0]                        cmd,
  input  logic [31:0]                       now_ticks,
  input  logic [31:0]                       sleep_us,
  input  logic [3:0]                        target_slot,
  input  logic [7:0]                        ticks_per_us,
  input  logic                              out_free,
  output logic                              idle,
  output logic                              res_valid,
  output rrts_pkg::res_t                    res,
  output logic [$clog2(TABLE_SLOTS)-1:0]    tbl_addr,
  output rrts_pkg::tbl_ctl_t                tbl_ctl,
  output logic [31:0]                       wk_wdata,
  input  rrts_pkg::slot_state_t             st_rd,
  input  logic [31:0]                       wk_rd
);

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ADD, S_SLP_MUL, S_SLP_ADD, S_BLOCK, S_WAKE, S_TERM,
    S_SCAN_INIT, S_SCAN, S_SCAN_WAKE, S_YLD_FIN, S_DONE
  } seq_state_t;

  seq_state_t     state_r, state_nxt;
  logic [CW-1:0]  slot_count_r, slot_count_nxt;
  logic [CW-1:0]  scan_pos_r, scan_pos_nxt;
  logic [SW-1:0]  current_r, current_nxt;
  logic           cur_gone_r, cur_gone_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [31:0]    prod_r, prod_nxt;
  rrts_pkg::res_t res_r, res_nxt;

  logic [31:0]    op_a, op_b, sum;
  logic           op_cin;
  logic [CW-1:0]  nn_inc, nn;
  logic           cur_running;
  logic           target_ok;

  assign nn_inc      = CW'(n_r + 1'b1);
  assign nn          = (nn_inc >= slot_count_r) ? '0 : nn_inc;
  assign cur_running = !cur_gone_r && (st_rd == rrts_pkg::ST_RUNNING);
  assign target_ok   = 7'(target_slot) < 7'(TABLE_SLOTS);

  always_comb begin
    if (state_r == S_SLP_ADD) begin
      op_a   = now_ticks;
      op_b   = prod_r;
      op_cin = 1'b0;
    end else begin
      op_a   = wk_rd;
      op_b   = ~now_ticks;
      op_cin = 1'b1;
    end
    sum = 32'(op_a + op_b + 32'(op_cin));
  end

  assign wk_wdata  = sum;
  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt      = state_r;
    slot_count_nxt = slot_count_r;
    scan_pos_nxt   = scan_pos_r;
    current_nxt    = current_r;
    cur_gone_nxt   = cur_gone_r;
    n_nxt          = n_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    prod_nxt       = prod_r;
    res_nxt        = res_r;
    tbl_addr       = current_r;
    tbl_ctl        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_nxt.status    = rrts_pkg::STAT_OK;
        res_nxt.task_slot = 4'(current_r);
        res_nxt.switched  = 1'b0;
        idx_nxt           = '0;
        case (cmd)
          rrts_pkg::CMD_ADD:   state_nxt = S_ADD;
          rrts_pkg::CMD_YIELD: state_nxt = S_SCAN_INIT;
          rrts_pkg::CMD_SLEEP: state_nxt = (sleep_us == 32'd0) ? S_DONE : S_SLP_MUL;
          rrts_pkg::CMD_BLOCK: state_nxt = S_BLOCK;
          rrts_pkg::CMD_WAKE:  state_nxt = S_WAKE;
          rrts_pkg::CMD_TERM:  state_nxt = S_TERM;
          default:             state_nxt = S_DONE;
        endcase
      end
      S_ADD: begin
        tbl_addr = idx_r[SW-1:0];
        if (idx_r == slot_count_r) begin
          if (slot_count_r >= CW'(TABLE_SLOTS)) begin
            res_nxt.status    = rrts_pkg::STAT_FULL;
            res_nxt.task_slot = 4'd0;
          end else begin
            tbl_ctl.st_we     = 1'b1;
            tbl_ctl.st_wdata  = rrts_pkg::ST_READY;
            res_nxt.task_slot = 4'(slot_count_r);
            slot_count_nxt    = CW'(slot_count_r + 1'b1);
          end
          state_nxt = S_DONE;
        end else if (st_rd == rrts_pkg::ST_FREE) begin
          tbl_ctl.st_we     = 1'b1;
          tbl_ctl.st_wdata  = rrts_pkg::ST_READY;
          res_nxt.task_slot = 4'(idx_r);
          state_nxt         = S_DONE;
        end else begin
          idx_nxt = CW'(idx_r + 1'b1);
        end
      end
      S_SLP_MUL: begin
        prod_nxt  = 32'(sleep_us * 32'(ticks_per_us));
        state_nxt = S_SLP_ADD;
      end
      S_SLP_ADD: begin
        if (cur_running) begin
          tbl_ctl.st_we    = 1'b1;
          tbl_ctl.st_wdata = rrts_pkg::ST_SLEEPING;
          tbl_ctl.wk_we    = 1'b1;
        end
        state_nxt = S_SCAN_INIT;
      end
      S_BLOCK: begin
        if (cur_running) begin
          tbl_ctl.st_we    = 1'b1;
          tbl_ctl.st_wdata = rrts_pkg::ST_BLOCKED;
        end
        state_nxt = S_SCAN_INIT;
      end
      S_WAKE: begin
        tbl_addr          = SW'(target_slot);
        res_nxt.task_slot = target_slot;
        if (target_ok && st_rd == rrts_pkg::ST_BLOCKED) begin
          tbl_ctl.st_we    = 1'b1;
          tbl_ctl.st_wdata = rrts_pkg::ST_READY;
        end else begin
          res_nxt.status = rrts_pkg::STAT_NOT_BLOCKED;
        end
        state_nxt = S_DONE;
      end
      S_TERM: begin
        if (!cur_gone_r && st_rd != rrts_pkg::ST_FREE) begin
          tbl_ctl.st_we    = 1'b1;
          tbl_ctl.st_wdata = rrts_pkg::ST_TERM;
        end
        state_nxt = S_DONE;
      end
      S_SCAN_INIT: begin
        n_nxt     = (scan_pos_r < CW'(TABLE_SLOTS)) ? scan_pos_r : '0;
        cnt_nxt   = slot_count_r;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        tbl_addr = nn[SW-1:0];
        n_nxt    = nn;
        cnt_nxt  = CW'(cnt_r - 1'b1);
        if (cnt_r == '0) begin
          scan_pos_nxt      = CW'(TABLE_SLOTS);
          res_nxt.status    = rrts_pkg::STAT_NONE;
          res_nxt.task_slot = (cmd == rrts_pkg::CMD_BLOCK) ? 4'(current_r) : 4'd0;
          res_nxt.switched  = 1'b0;
          state_nxt         = S_DONE;
        end else begin
          case (st_rd)
            rrts_pkg::ST_READY: begin
              tbl_ctl.st_we    = 1'b1;
              tbl_ctl.st_wdata = rrts_pkg::ST_RUNNING;
              state_nxt        = S_YLD_FIN;
            end
            rrts_pkg::ST_RUNNING: begin
              if (nn[SW-1:0] == current_r && !cur_gone_r) begin
                state_nxt = S_YLD_FIN;
              end
            end
            rrts_pkg::ST_SLEEPING: begin
              state_nxt = S_SCAN_WAKE;
            end
            rrts_pkg::ST_TERM: begin
              tbl_ctl.st_we    = 1'b1;
              tbl_ctl.st_wdata = rrts_pkg::ST_FREE;
              if (CW'(nn + 1'b1) == slot_count_r) begin
                slot_count_nxt = CW'(slot_count_r - 1'b1);
              end
              if (nn[SW-1:0] == current_r) begin
                cur_gone_nxt = 1'b1;
              end
              scan_pos_nxt      = CW'(TABLE_SLOTS);
              res_nxt.status    = rrts_pkg::STAT_NONE;
              res_nxt.task_slot = (cmd == rrts_pkg::CMD_BLOCK) ? 4'(current_r) : 4'd0;
              res_nxt.switched  = 1'b0;
              state_nxt         = S_DONE;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN_WAKE: begin
        tbl_addr = n_r[SW-1:0];
        if (sum != 32'd0 && !sum[31]) begin
          state_nxt = S_SCAN;
        end else begin
          tbl_ctl.st_we    = 1'b1;
          tbl_ctl.st_wdata = rrts_pkg::ST_RUNNING;
          state_nxt        = S_YLD_FIN;
        end
      end
      S_YLD_FIN: begin
        scan_pos_nxt      = n_r;
        res_nxt.status    = rrts_pkg::STAT_OK;
        res_nxt.task_slot = (cmd == rrts_pkg::CMD_BLOCK) ? 4'(current_r) : 4'(n_r);
        if (n_r[SW-1:0] == current_r && !cur_gone_r) begin
          res_nxt.switched = 1'b0;
        end else begin
          if (cur_running) begin
            tbl_ctl.st_we    = 1'b1;
            tbl_ctl.st_wdata = rrts_pkg::ST_READY;
          end
          current_nxt      = n_r[SW-1:0];
          cur_gone_nxt     = 1'b0;
          res_nxt.switched = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_count_r <= CW'(1);
      scan_pos_r   <= '0;
      current_r    <= '0;
      cur_gone_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_count_r <= slot_count_nxt;
      scan_pos_r   <= scan_pos_nxt;
      current_r    <= current_nxt;
      cur_gone_r   <= cur_gone_nxt;
    end
    n_r    <= n_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

endmodule

FILE: hw/rtl/rrts_checker.sv
// Port-level checks for the round robin task selector and their bind to the top level.
`include "assert_macros.svh"

module rrts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [7:0]  cfg_wdata,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_cmd,
  input logic [31:0] in_now_ticks,
  input logic [31:0] in_sleep_us,
  input logic [3:0]  in_target_slot,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [3:0]  out_task_slot,
  input logic        out_switched
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_task_slot) && $stable(out_switched))
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `ASSERT_IMPL(a_switch_ok, clk, rst_n, out_valid && out_switched, out_status == rrts_pkg::STAT_OK)
  `ASSERT_IMPL(a_full_slot0, clk, rst_n, out_valid && out_status == rrts_pkg::STAT_FULL, out_task_slot == 4'd0 && !out_switched)

endmodule

bind round_robin_task_selector rrts_checker u_rrts_checker (.*);

FILE: tb/sv/rrts_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the round robin task selector: mirrors the task table and checks each result word.
module rrts_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_now_ticks,
  input  logic [31:0] in_sleep_us,
  input  logic [3:0]  in_target_slot,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [3:0]  out_task_slot,
  input  logic        out_switched,
  output int          results_due,
  output int          mismatch_count
);

  localparam int SLOTS = 16;

  rrts_pkg::slot_state_t slot_st [SLOTS];
  logic [31:0]           wake_at [SLOTS];
  int                    used_cnt;
  int                    scan_at;
  int                    cur_slot;
  bit                    cur_freed;
  logic [7:0]            tick_rate;
  rrts_pkg::res_t        sched_results_q [$];
  int                    errs = 0;

  initial begin
    results_due    = 0;
    mismatch_count = 0;
  end

  function automatic bit cur_alive();
    return !cur_freed && slot_st[cur_slot] == rrts_pkg::ST_RUNNING;
  endfunction

  // Walks the slots in use at most once, starting after the last chosen slot; a terminated slot ends the walk.
  function automatic int scan_ready(input logic [31:0] now);
    int          n;
    int          i;
    logic [31:0] gap;
    n = (scan_at < SLOTS) ? scan_at : 0;
    for (i = 1; i <= used_cnt; i++) begin
      n++;
      if (n >= used_cnt) n = 0;
      case (slot_st[n])
        rrts_pkg::ST_READY: begin
          slot_st[n] = rrts_pkg::ST_RUNNING;
          return n;
        end
        rrts_pkg::ST_RUNNING: begin
          if (n == cur_slot && !cur_freed) return n;
        end
        rrts_pkg::ST_SLEEPING: begin
          gap = wake_at[n] - now;
          if (gap == 32'd0 || gap[31]) begin
            slot_st[n] = rrts_pkg::ST_RUNNING;
            return n;
          end
        end
        rrts_pkg::ST_TERM: begin
          slot_st[n] = rrts_pkg::ST_FREE;
          if (n + 1 == used_cnt) used_cnt--;
          if (n == cur_slot) cur_freed = 1'b1;
          return SLOTS;
        end
        default: ;
      endcase
    end
    return SLOTS;
  endfunction

  function automatic rrts_pkg::res_t yield_slot(input logic [31:0] now);
    rrts_pkg::res_t r;
    int             n;
    n = scan_ready(now);
    scan_at = n;
    r.status    = rrts_pkg::STAT_OK;
    r.task_slot = 4'(n);
    r.switched  = 1'b0;
    if (n >= SLOTS) begin
      r.status    = rrts_pkg::STAT_NONE;
      r.task_slot = 4'd0;
      return r;
    end
    if (n == cur_slot && !cur_freed) return r;
    if (!cur_freed && slot_st[cur_slot] == rrts_pkg::ST_RUNNING)
      slot_st[cur_slot] = rrts_pkg::ST_READY;
    cur_slot   = n;
    cur_freed  = 1'b0;
    r.switched = 1'b1;
    return r;
  endfunction

  function automatic rrts_pkg::res_t schedule_word(input logic [2:0] cmd,
                                                   input logic [31:0] now,
                                                   input logic [31:0] us,
                                                   input logic [3:0] target);
    rrts_pkg::res_t r;
    int             i;
    bit             found;
    logic [3:0]     held;
    r.status    = rrts_pkg::STAT_OK;
    r.task_slot = 4'(cur_slot);
    r.switched  = 1'b0;
    case (cmd)
      rrts_pkg::CMD_ADD: begin
        found = 1'b0;
        for (i = 0; i < used_cnt && !found; i++) begin
          if (slot_st[i] == rrts_pkg::ST_FREE) begin
            slot_st[i]  = rrts_pkg::ST_READY;
            r.task_slot = 4'(i);
            found       = 1'b1;
          end
        end
        if (!found) begin
          if (used_cnt >= SLOTS) begin
            r.status    = rrts_pkg::STAT_FULL;
            r.task_slot = 4'd0;
          end else begin
            slot_st[used_cnt] = rrts_pkg::ST_READY;
            r.task_slot       = 4'(used_cnt);
            used_cnt++;
          end
        end
      end
      rrts_pkg::CMD_YIELD: r = yield_slot(now);
      rrts_pkg::CMD_SLEEP: begin
        if (us != 32'd0) begin
          if (cur_alive()) begin
            wake_at[cur_slot] = now + us * {24'd0, tick_rate};
            slot_st[cur_slot] = rrts_pkg::ST_SLEEPING;
          end
          r = yield_slot(now);
        end
      end
      rrts_pkg::CMD_BLOCK: begin
        held = 4'(cur_slot);
        if (cur_alive()) slot_st[cur_slot] = rrts_pkg::ST_BLOCKED;
        r = yield_slot(now);
        r.task_slot = held;
      end
      rrts_pkg::CMD_WAKE: begin
        r.task_slot = target;
        if (slot_st[target] != rrts_pkg::ST_BLOCKED) r.status = rrts_pkg::STAT_NOT_BLOCKED;
        else slot_st[target] = rrts_pkg::ST_READY;
      end
      rrts_pkg::CMD_TERM: begin
        if (!cur_freed && slot_st[cur_slot] != rrts_pkg::ST_FREE)
          slot_st[cur_slot] = rrts_pkg::ST_TERM;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    rrts_pkg::res_t want;
    int             i;
    if (!rst_n) begin
      for (i = 0; i < SLOTS; i++) begin
        slot_st[i] = rrts_pkg::ST_FREE;
        wake_at[i] = 32'd0;
      end
      slot_st[0] = rrts_pkg::ST_RUNNING;
      used_cnt   = 1;
      scan_at    = 0;
      cur_slot   = 0;
      cur_freed  = 1'b0;
      tick_rate  = 8'd1;
      sched_results_q.delete();
    end else begin
      if (cfg_we) tick_rate = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (sched_results_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected result word: status %0d slot %0d switched %0d",
                     $realtime, out_status, out_task_slot, out_switched);
        end else begin
          want = sched_results_q.pop_front();
          if (out_status != want.status || out_task_slot != want.task_slot ||
              out_switched != want.switched) begin
            errs++;
            if (errs <= 10)
              $display({"%0t: result mismatch: expected status %0d slot %0d switched %0d,",
                        " got status %0d slot %0d switched %0d"},
                       $realtime, want.status, want.task_slot, want.switched,
                       out_status, out_task_slot, out_switched);
          end
        end
      end
      if (in_valid && !in_stall)
        sched_results_q.push_back(schedule_word(in_cmd, in_now_ticks, in_sleep_us,
                                                in_target_slot));
    end
    results_due    <= sched_results_q.size();
    mismatch_count <= errs;
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the round robin task selector: clock, reset, command stimulus and verdict.
module tb;

  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;
  localparam int PHASE_WORDS = 113;
  localparam int SETTLE_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = 3'd0;
  logic [31:0] in_now_ticks = 32'd0;
  logic [31:0] in_sleep_us = 32'd0;
  logic [3:0]  in_target_slot = 4'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_task_slot;
  logic        out_switched;
  int          results_due;
  int          mismatch_count;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic [31:0] tick_now = 32'd0;

  round_robin_task_selector #(.TABLE_SLOTS(16)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_now_ticks(in_now_ticks), .in_sleep_us(in_sleep_us),
    .in_target_slot(in_target_slot), .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_task_slot(out_task_slot), .out_switched(out_switched)
  );

  rrts_scoreboard chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_now_ticks(in_now_ticks), .in_sleep_us(in_sleep_us),
    .in_target_slot(in_target_slot), .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_task_slot(out_task_slot), .out_switched(out_switched),
    .results_due(results_due), .mismatch_count(mismatch_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_word(input logic [2:0] cmd, input logic [31:0] now,
                           input logic [31:0] us, input logic [3:0] target);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_now_ticks   <= now;
    in_sleep_us    <= us;
    in_target_slot <= target;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic set_rate(input logic [7:0] rate);
    cfg_we    <= 1'b1;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word();
    int          pick;
    logic [2:0]  cmd;
    logic [31:0] us;
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0) tick_now = $urandom();
    else tick_now = tick_now + $urandom_range(60);
    if (pick < 22) cmd = rrts_pkg::CMD_ADD;
    else if (pick < 52) cmd = rrts_pkg::CMD_YIELD;
    else if (pick < 66) cmd = rrts_pkg::CMD_SLEEP;
    else if (pick < 76) cmd = rrts_pkg::CMD_BLOCK;
    else if (pick < 90) cmd = rrts_pkg::CMD_WAKE;
    else if (pick < 96) cmd = rrts_pkg::CMD_TERM;
    else if (pick < 98) cmd = CMD_RSVD_A;
    else cmd = CMD_RSVD_B;
    pick = $urandom_range(9);
    if (pick == 0) us = 32'd0;
    else if (pick == 1) us = $urandom();
    else us = $urandom_range(1, 40);
    send_word(cmd, tick_now, us, 4'($urandom_range(15)));
  endtask

  task automatic run_phase(input logic [7:0] rate, input int idle, input int stall);
    drain();
    set_rate(rate);
    idle_pct = idle;
    stall_pct <= stall;
    repeat (PHASE_WORDS) random_word();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_rate(8'd1);

    send_word(rrts_pkg::CMD_YIELD, 32'hFFFF_FFFF, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_ADD, 32'd1, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_ADD, 32'd2, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_YIELD, 32'd3, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_SLEEP, 32'd4, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_SLEEP, 32'hFFFF_FFF0, 32'd5, 4'd0);
    send_word(rrts_pkg::CMD_BLOCK, 32'hFFFF_FFF1, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_WAKE, 32'hFFFF_FFF2, 32'd0, 4'd2);
    send_word(rrts_pkg::CMD_WAKE, 32'hFFFF_FFF3, 32'd0, 4'd15);
    send_word(rrts_pkg::CMD_YIELD, 32'h0000_0010, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_TERM, 32'h0000_0011, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_YIELD, 32'h0000_0012, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_TERM, 32'h0000_0013, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_YIELD, 32'h0000_0014, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_YIELD, 32'h0000_0015, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_YIELD, 32'h0000_0016, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_YIELD, 32'h0000_0017, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_TERM, 32'h0000_0018, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_YIELD, 32'h0000_0019, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_SLEEP, 32'h0000_001A, 32'hFFFF_FFFF, 4'd0);
    send_word(rrts_pkg::CMD_TERM, 32'h0000_001B, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_ADD, 32'h0000_001C, 32'd0, 4'd0);
    send_word(rrts_pkg::CMD_YIELD, 32'h0000_001D, 32'd0, 4'd0);
    send_word(CMD_RSVD_A, 32'h0000_001E, 32'd9, 4'd5);
    send_word(CMD_RSVD_B, 32'h0000_001F, 32'd0, 4'd10);

    run_phase(8'd255, 0, 0);
    run_phase(8'd0, 72, 0);
    run_phase(8'($urandom_range(2, 254)), 0, 72);
    run_phase(8'd1, 15, 15);
    run_phase(8'($urandom_range(1, 255)), 0, 72);
    run_phase(8'd255, 0, 0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_table.sv
hw/rtl/rrts_seq.sv
hw/rtl/round_robin_task_selector.sv
hw/rtl/rrts_checker.sv
tb/sv/rrts_checker.sv
tb/sv/tb.sv
